>>> rtl/psue_pkg.sv
// Shared constants, types and helper functions of the particle swarm update engine.
`default_nettype none
package psue_pkg;

  localparam int PARTICLES = 64;
  localparam int DIMS = 16;
  localparam int PW = $clog2(PARTICLES);
  localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int AW = $clog2(PARTICLES * DIMS);

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [2:0] OP_BOUNDS = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_REPORT = 3'd2;
  localparam logic [2:0] OP_MOVE   = 3'd3;
  localparam logic [2:0] OP_ENDGEN = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [2:0] REG_TOPOLOGY   = 3'd0;
  localparam logic [2:0] REG_BOUND_POS  = 3'd1;
  localparam logic [2:0] REG_BOUND_VEL  = 3'd2;
  localparam logic [2:0] REG_INERTIA    = 3'd3;
  localparam logic [2:0] REG_OWN_PULL   = 3'd4;
  localparam logic [2:0] REG_SWARM_PULL = 3'd5;

  localparam logic [15:0] INERTIA_RST = 16'd11957;
  localparam logic [15:0] PULL_RST    = 16'd24513;

  typedef struct packed {
    logic        topology;
    logic        bound_position;
    logic        bound_velocity;
    logic [15:0] inertia;
    logic [15:0] own_pull;
    logic [15:0] swarm_pull;
  } cfg_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LATCH, CMD_BOUNDS, CMD_LOAD, CMD_PERR_SELF, CMD_FLAGS,
    CMD_CAND_RD, CMD_CAND_WR, CMD_RPT_FIN, CMD_MV_LEFT, CMD_MV_RIGHT, CMD_MV_X,
    CMD_MV_NB, CMD_MV_M2, CMD_MV_M3, CMD_MV_M4, CMD_MV_M5, CMD_MV_SUM,
    CMD_MV_VEL, CMD_MV_POS, CMD_SC_INIT, CMD_SC_RD, CMD_SC_CMP, CMD_CB_RD,
    CMD_CB_WR, CMD_SC_NEXT, CMD_RD_BEST, CMD_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       p_ok;
    logic       d_ok;
    logic       topology;
    logic       cnt_last;
    logic       sc_last;
    logic       sc_take;
  } dp_status_t;

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] x,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic [AW-1:0] elem_addr(input logic [PW-1:0] p,
                                              input logic [DW-1:0] d);
    return AW'(int'(p) * DIMS + int'(d));
  endfunction

endpackage
`default_nettype wire

>>> rtl/psue_ctrl.sv
// Controller state machine that sequences the datapath for each operation.
`default_nettype none
module psue_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire psue_pkg::dp_status_t status,
  output psue_pkg::dp_cmd_t         cmd
);

  typedef enum logic [22:0] {
    S_IDLE      = 23'h000001,
    S_EXEC      = 23'h000002,
    S_RPT_FLAGS = 23'h000004,
    S_CAND_RD   = 23'h000008,
    S_CAND_WR   = 23'h000010,
    S_RPT_FIN   = 23'h000020,
    S_MV_LEFT   = 23'h000040,
    S_MV_RIGHT  = 23'h000080,
    S_MV_X      = 23'h000100,
    S_MV_NB     = 23'h000200,
    S_MV_M2     = 23'h000400,
    S_MV_M3     = 23'h000800,
    S_MV_M4     = 23'h001000,
    S_MV_M5     = 23'h002000,
    S_MV_SUM    = 23'h004000,
    S_MV_VEL    = 23'h008000,
    S_MV_POS    = 23'h010000,
    S_SC_RD     = 23'h020000,
    S_SC_CMP    = 23'h040000,
    S_CB_RD     = 23'h080000,
    S_CB_WR     = 23'h100000,
    S_SC_NEXT   = 23'h200000,
    S_DONE      = 23'h400000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = psue_pkg::CMD_NONE;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd = psue_pkg::CMD_LATCH;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (status.op)
          psue_pkg::OP_BOUNDS: if (status.d_ok) cmd = psue_pkg::CMD_BOUNDS;
          psue_pkg::OP_LOAD: if (status.p_ok && status.d_ok) cmd = psue_pkg::CMD_LOAD;
          psue_pkg::OP_REPORT: if (status.p_ok) begin
            cmd = psue_pkg::CMD_PERR_SELF;
            state_next = S_RPT_FLAGS;
          end
          psue_pkg::OP_MOVE: if (status.p_ok && status.d_ok) begin
            cmd = psue_pkg::CMD_PERR_SELF;
            state_next = S_MV_LEFT;
          end
          psue_pkg::OP_ENDGEN: if (status.topology) begin
            cmd = psue_pkg::CMD_SC_INIT;
            state_next = S_SC_RD;
          end
          psue_pkg::OP_READ: if (status.d_ok) cmd = psue_pkg::CMD_RD_BEST;
          default: ;
        endcase
      end
      S_RPT_FLAGS: begin
        cmd = psue_pkg::CMD_FLAGS;
        state_next = S_CAND_RD;
      end
      S_CAND_RD: begin
        cmd = psue_pkg::CMD_CAND_RD;
        state_next = S_CAND_WR;
      end
      S_CAND_WR: begin
        cmd = psue_pkg::CMD_CAND_WR;
        state_next = status.cnt_last ? S_RPT_FIN : S_CAND_RD;
      end
      S_RPT_FIN: begin
        cmd = psue_pkg::CMD_RPT_FIN;
        state_next = S_DONE;
      end
      S_MV_LEFT: begin
        cmd = psue_pkg::CMD_MV_LEFT;
        state_next = S_MV_RIGHT;
      end
      S_MV_RIGHT: begin
        cmd = psue_pkg::CMD_MV_RIGHT;
        state_next = S_MV_X;
      end
      S_MV_X: begin
        cmd = psue_pkg::CMD_MV_X;
        state_next = S_MV_NB;
      end
      S_MV_NB: begin
        cmd = psue_pkg::CMD_MV_NB;
        state_next = S_MV_M2;
      end
      S_MV_M2: begin
        cmd = psue_pkg::CMD_MV_M2;
        state_next = S_MV_M3;
      end
      S_MV_M3: begin
        cmd = psue_pkg::CMD_MV_M3;
        state_next = S_MV_M4;
      end
      S_MV_M4: begin
        cmd = psue_pkg::CMD_MV_M4;
        state_next = S_MV_M5;
      end
      S_MV_M5: begin
        cmd = psue_pkg::CMD_MV_M5;
        state_next = S_MV_SUM;
      end
      S_MV_SUM: begin
        cmd = psue_pkg::CMD_MV_SUM;
        state_next = S_MV_VEL;
      end
      S_MV_VEL: begin
        cmd = psue_pkg::CMD_MV_VEL;
        state_next = S_MV_POS;
      end
      S_MV_POS: begin
        cmd = psue_pkg::CMD_MV_POS;
        state_next = S_DONE;
      end
      S_SC_RD: begin
        cmd = psue_pkg::CMD_SC_RD;
        state_next = S_SC_CMP;
      end
      S_SC_CMP: begin
        cmd = psue_pkg::CMD_SC_CMP;
        state_next = status.sc_take ? S_CB_RD : S_SC_NEXT;
      end
      S_CB_RD: begin
        cmd = psue_pkg::CMD_CB_RD;
        state_next = S_CB_WR;
      end
      S_CB_WR: begin
        cmd = psue_pkg::CMD_CB_WR;
        state_next = status.cnt_last ? S_SC_NEXT : S_CB_RD;
      end
      S_SC_NEXT: begin
        cmd = psue_pkg::CMD_SC_NEXT;
        state_next = status.sc_last ? S_DONE : S_SC_RD;
      end
      S_DONE: if (!out_valid || out_ready) begin
        cmd = psue_pkg::CMD_EMIT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == psue_pkg::CMD_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule
`default_nettype wire

>>> rtl/psue_dp.sv
// Datapath with the swarm memories, the shared multiplier and the result register.
`default_nettype none
module psue_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire psue_pkg::cfg_t       cfg,
  input  wire psue_pkg::dp_cmd_t    cmd,
  output psue_pkg::dp_status_t      status,
  input  wire logic [2:0]           op,
  input  wire logic [5:0]           particle,
  input  wire logic [3:0]           dimension,
  input  wire logic signed [31:0]   value_a,
  input  wire logic signed [31:0]   value_b,
  input  wire logic [15:0]          rand_own,
  input  wire logic [15:0]          rand_swarm,
  input  wire logic [31:0]          error_value,
  output logic signed [31:0]        value_out,
  output logic [31:0]               gbest_error,
  output logic [5:0]                best_particle,
  output logic                      improved
);

  localparam int PW = psue_pkg::PW;
  localparam int DW = psue_pkg::DW;
  localparam int AW = psue_pkg::AW;
  localparam logic signed [38:0] V_MAX = 39'sd2147483647;
  localparam logic signed [38:0] V_MIN = -39'sd2147483648;
  localparam logic signed [32:0] P_MAX = 33'sd2147483647;
  localparam logic signed [32:0] P_MIN = -33'sd2147483648;

  logic signed [31:0] pos_mem [psue_pkg::PARTICLES*psue_pkg::DIMS];
  logic signed [31:0] vel_mem [psue_pkg::PARTICLES*psue_pkg::DIMS];
  logic signed [31:0] pb_mem  [psue_pkg::PARTICLES*psue_pkg::DIMS];
  logic [31:0]        perr_mem [psue_pkg::PARTICLES];
  logic [psue_pkg::PARTICLES-1:0] perr_vld;
  logic signed [31:0] gbest  [psue_pkg::DIMS];
  logic signed [31:0] lo_lim [psue_pkg::DIMS];
  logic signed [31:0] hi_lim [psue_pkg::DIMS];

  logic [2:0]         op_q;
  logic [PW-1:0]      p_q, sel_q, sidx;
  logic [DW-1:0]      d_q, cnt;
  logic               pok, dok, imp_p, imp_g, imp_q;
  logic signed [31:0] a_q, b_q, x_q, v_q, pbv_q, nb_q, vnew_q, vout_q;
  logic [15:0]        ro_q, rs_q, c1_q, c2_q;
  logic [31:0]        err_q, gerr, best_e;
  logic [PW-1:0]      gidx;

  logic signed [31:0] pos_rd, vel_rd, pb_rd;
  logic [31:0]        perr_rd;
  logic               vld_rd;
  logic [31:0]        perr_eff;

  logic [AW-1:0]      k_addr, pos_raddr, pb_raddr;
  logic [PW-1:0]      perr_raddr, left_p, right_p;
  logic [DW-1:0]      li;
  logic signed [31:0] lo_sel, hi_sel, cand_src, cand;

  logic signed [16:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [50:0] mul_q;
  logic signed [52:0] acc, rnd;
  logic signed [38:0] nv, nvc;
  logic signed [32:0] span, span_abs, np, npc;
  logic signed [31:0] vnew, pnew;

  assign perr_eff = vld_rd ? perr_rd : psue_pkg::ALL_ONES;
  assign k_addr = psue_pkg::elem_addr(p_q, d_q);
  assign left_p = (p_q == '0) ? PW'(psue_pkg::PARTICLES - 1) : p_q - 1'b1;
  assign right_p = (p_q == PW'(psue_pkg::PARTICLES - 1)) ? '0 : p_q + 1'b1;

  always_comb begin
    pos_raddr = (cmd == psue_pkg::CMD_CAND_RD) ? psue_pkg::elem_addr(p_q, cnt) : k_addr;
    case (cmd)
      psue_pkg::CMD_MV_NB: pb_raddr = psue_pkg::elem_addr(sel_q, d_q);
      psue_pkg::CMD_CB_RD: pb_raddr = psue_pkg::elem_addr(sidx, cnt);
      default: pb_raddr = k_addr;
    endcase
    case (cmd)
      psue_pkg::CMD_MV_LEFT: perr_raddr = left_p;
      psue_pkg::CMD_MV_RIGHT: perr_raddr = right_p;
      psue_pkg::CMD_SC_RD: perr_raddr = sidx;
      default: perr_raddr = p_q;
    endcase
    li = ((cmd == psue_pkg::CMD_CAND_WR) || (cmd == psue_pkg::CMD_CB_WR)) ? cnt : d_q;
    lo_sel = lo_lim[li];
    hi_sel = hi_lim[li];
    cand_src = (cmd == psue_pkg::CMD_CB_WR) ? pb_rd : pos_rd;
    cand = cfg.bound_position ? cand_src : psue_pkg::clamp32(cand_src, lo_sel, hi_sel);
  end

  always_comb begin
    case (cmd)
      psue_pkg::CMD_MV_NB: begin
        mul_a = {1'b0, ro_q};
        mul_b = {18'b0, cfg.own_pull};
      end
      psue_pkg::CMD_MV_M2: begin
        mul_a = {1'b0, rs_q};
        mul_b = {18'b0, cfg.swarm_pull};
      end
      psue_pkg::CMD_MV_M3: begin
        mul_a = {1'b0, cfg.inertia};
        mul_b = 34'(v_q);
      end
      psue_pkg::CMD_MV_M4: begin
        mul_a = {1'b0, c1_q};
        mul_b = 34'(pbv_q) - 34'(x_q);
      end
      default: begin
        mul_a = {1'b0, c2_q};
        mul_b = 34'(nb_q) - 34'(x_q);
      end
    endcase
  end

  always_comb begin
    rnd = acc + 53'sd8192;
    nv = 39'(rnd >>> 14);
    span = 33'(hi_sel) - 33'(lo_sel);
    span_abs = (span < 0) ? -span : span;
    nvc = nv;
    if (cfg.bound_velocity) begin
      if (nv < -39'(span_abs)) nvc = -39'(span_abs);
      else if (nv > 39'(span_abs)) nvc = 39'(span_abs);
    end
    if (nvc > V_MAX) vnew = 32'(V_MAX);
    else if (nvc < V_MIN) vnew = 32'(V_MIN);
    else vnew = 32'(nvc);
    np = 33'(x_q) + 33'(vnew_q);
    npc = np;
    if (cfg.bound_position) begin
      if (np < 33'(lo_sel)) npc = 33'(lo_sel);
      else if (np > 33'(hi_sel)) npc = 33'(hi_sel);
    end
    if (npc > P_MAX) pnew = 32'(P_MAX);
    else if (npc < P_MIN) pnew = 32'(P_MIN);
    else pnew = 32'(npc);
  end

  always_ff @(posedge clk) begin
    if (cmd == psue_pkg::CMD_LOAD) pos_mem[k_addr] <= a_q;
    else if (cmd == psue_pkg::CMD_MV_POS) pos_mem[k_addr] <= pnew;
    pos_rd <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd == psue_pkg::CMD_LOAD) vel_mem[k_addr] <= b_q;
    else if (cmd == psue_pkg::CMD_MV_VEL) vel_mem[k_addr] <= vnew;
    vel_rd <= vel_mem[k_addr];
  end

  always_ff @(posedge clk) begin
    if ((cmd == psue_pkg::CMD_CAND_WR) && imp_p) pb_mem[psue_pkg::elem_addr(p_q, cnt)] <= cand;
    pb_rd <= pb_mem[pb_raddr];
  end

  always_ff @(posedge clk) begin
    if ((cmd == psue_pkg::CMD_RPT_FIN) && imp_p) perr_mem[p_q] <= err_q;
    perr_rd <= perr_mem[perr_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perr_vld <= '0;
      gerr <= psue_pkg::ALL_ONES;
      gidx <= '0;
    end else begin
      case (cmd)
        psue_pkg::CMD_LOAD: begin
          perr_vld[p_q] <= 1'b0;
          gerr <= psue_pkg::ALL_ONES;
          gidx <= '0;
        end
        psue_pkg::CMD_RPT_FIN: begin
          if (imp_p) perr_vld[p_q] <= 1'b1;
          if (imp_g) begin
            gerr <= err_q;
            gidx <= p_q;
          end
        end
        psue_pkg::CMD_SC_INIT: gerr <= psue_pkg::ALL_ONES;
        psue_pkg::CMD_SC_CMP: if (status.sc_take) begin
          gerr <= perr_eff;
          gidx <= sidx;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    vld_rd <= perr_vld[perr_raddr];
    mul_q <= mul_a * mul_b;
    case (cmd)
      psue_pkg::CMD_LATCH: begin
        op_q <= op;
        p_q <= PW'(particle);
        d_q <= DW'(dimension);
        pok <= 32'(particle) < 32'(psue_pkg::PARTICLES);
        dok <= 32'(dimension) < 32'(psue_pkg::DIMS);
        a_q <= value_a;
        b_q <= value_b;
        ro_q <= rand_own;
        rs_q <= rand_swarm;
        err_q <= error_value;
        vout_q <= '0;
        imp_q <= 1'b0;
      end
      psue_pkg::CMD_BOUNDS: begin
        lo_lim[d_q] <= a_q;
        hi_lim[d_q] <= b_q;
      end
      psue_pkg::CMD_FLAGS: begin
        imp_p <= err_q < perr_eff;
        imp_g <= !cfg.topology && (err_q < gerr);
        cnt <= '0;
      end
      psue_pkg::CMD_CAND_WR: begin
        if (imp_g) gbest[cnt] <= cand;
        cnt <= cnt + 1'b1;
      end
      psue_pkg::CMD_RPT_FIN: imp_q <= imp_p;
      psue_pkg::CMD_MV_LEFT: begin
        best_e <= perr_eff;
        sel_q <= p_q;
      end
      psue_pkg::CMD_MV_RIGHT: if (perr_eff < best_e) begin
        best_e <= perr_eff;
        sel_q <= left_p;
      end
      psue_pkg::CMD_MV_X: if (perr_eff < best_e) sel_q <= right_p;
      psue_pkg::CMD_MV_NB: begin
        x_q <= pos_rd;
        v_q <= vel_rd;
        pbv_q <= pb_rd;
      end
      psue_pkg::CMD_MV_M2: begin
        c1_q <= mul_q[31:16];
        nb_q <= cfg.topology ? pb_rd : gbest[d_q];
      end
      psue_pkg::CMD_MV_M3: c2_q <= mul_q[31:16];
      psue_pkg::CMD_MV_M4: acc <= 53'(mul_q);
      psue_pkg::CMD_MV_M5, psue_pkg::CMD_MV_SUM: acc <= acc + 53'(mul_q);
      psue_pkg::CMD_MV_VEL: vnew_q <= vnew;
      psue_pkg::CMD_MV_POS: vout_q <= psue_pkg::clamp32(pnew, lo_sel, hi_sel);
      psue_pkg::CMD_SC_INIT: sidx <= '0;
      psue_pkg::CMD_SC_CMP: cnt <= '0;
      psue_pkg::CMD_CB_WR: begin
        gbest[cnt] <= cand;
        cnt <= cnt + 1'b1;
      end
      psue_pkg::CMD_SC_NEXT: sidx <= sidx + 1'b1;
      psue_pkg::CMD_RD_BEST: vout_q <= gbest[d_q];
      psue_pkg::CMD_EMIT: begin
        value_out <= vout_q;
        gbest_error <= gerr;
        best_particle <= 6'(gidx);
        improved <= imp_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.op = op_q;
    status.p_ok = pok;
    status.d_ok = dok;
    status.topology = cfg.topology;
    status.cnt_last = (cnt == DW'(psue_pkg::DIMS - 1));
    status.sc_last = (sidx == PW'(psue_pkg::PARTICLES - 1));
    status.sc_take = perr_eff < gerr;
  end

endmodule
`default_nettype wire

>>> rtl/particle_swarm_update_engine.sv
// Top level of the particle swarm update engine with its configuration registers.
// The engine works on one transaction at a time and returns one result transaction
// for each. A move is sequenced by its chain of memory reads and the single shared
// multiplier used five times; an error report reads the candidate and writes it
// back one dimension at a time; an end of generation in ring mode scans every
// particle and copies the personal best of each particle that improves the
// running best. A new transaction is accepted in the cycle after a result is
// queued, even while that result still waits to be taken.
`default_nettype none
module particle_swarm_update_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         op,
  input  wire logic [5:0]         particle,
  input  wire logic [3:0]         dimension,
  input  wire logic signed [31:0] value_a,
  input  wire logic signed [31:0] value_b,
  input  wire logic [15:0]        rand_own,
  input  wire logic [15:0]        rand_swarm,
  input  wire logic [31:0]        error_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      value_out,
  output logic [31:0]             gbest_error,
  output logic [5:0]              best_particle,
  output logic                    improved
);

  psue_pkg::cfg_t       cfg;
  psue_pkg::dp_cmd_t    cmd;
  psue_pkg::dp_status_t status;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.topology <= 1'b0;
      cfg.bound_position <= 1'b0;
      cfg.bound_velocity <= 1'b0;
      cfg.inertia <= psue_pkg::INERTIA_RST;
      cfg.own_pull <= psue_pkg::PULL_RST;
      cfg.swarm_pull <= psue_pkg::PULL_RST;
    end else if (wr_en) begin
      case (paddr[4:2])
        psue_pkg::REG_TOPOLOGY: cfg.topology <= pwdata[0];
        psue_pkg::REG_BOUND_POS: cfg.bound_position <= pwdata[0];
        psue_pkg::REG_BOUND_VEL: cfg.bound_velocity <= pwdata[0];
        psue_pkg::REG_INERTIA: cfg.inertia <= pwdata[15:0];
        psue_pkg::REG_OWN_PULL: cfg.own_pull <= pwdata[15:0];
        psue_pkg::REG_SWARM_PULL: cfg.swarm_pull <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      psue_pkg::REG_TOPOLOGY: prdata = {31'b0, cfg.topology};
      psue_pkg::REG_BOUND_POS: prdata = {31'b0, cfg.bound_position};
      psue_pkg::REG_BOUND_VEL: prdata = {31'b0, cfg.bound_velocity};
      psue_pkg::REG_INERTIA: prdata = {16'b0, cfg.inertia};
      psue_pkg::REG_OWN_PULL: prdata = {16'b0, cfg.own_pull};
      psue_pkg::REG_SWARM_PULL: prdata = {16'b0, cfg.swarm_pull};
      default: prdata = '0;
    endcase
  end

  psue_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  psue_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .op            (op),
    .particle      (particle),
    .dimension     (dimension),
    .value_a       (value_a),
    .value_b       (value_b),
    .rand_own      (rand_own),
    .rand_swarm    (rand_swarm),
    .error_value   (error_value),
    .value_out     (value_out),
    .gbest_error   (gbest_error),
    .best_particle (best_particle),
    .improved      (improved)
  );

endmodule
`default_nettype wire

>>> rtl/psue_checker.sv
// Port-level checks of the particle swarm update engine and their binding.
`default_nettype none
module psue_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] value_out,
  input wire logic [31:0]        gbest_error,
  input wire logic               pready
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("engine accepted a transaction while busy");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(gbest_error))
    else $error("stalled result transaction changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("engine not idle after reset");

  a_pready_high: assert property (@(posedge clk) pready)
    else $error("configuration port not ready");

endmodule

bind particle_swarm_update_engine psue_checker u_psue_checker (.*);
`default_nettype wire

>>> dv/psue_checker.sv
// Scoreboard that predicts every result of the particle swarm update engine and compares.
`timescale 1ns / 100ps
module psue_scoreboard (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [2:0]         op,
  input  wire logic [5:0]         particle,
  input  wire logic [3:0]         dimension,
  input  wire logic signed [31:0] value_a,
  input  wire logic signed [31:0] value_b,
  input  wire logic [15:0]        rand_own,
  input  wire logic [15:0]        rand_swarm,
  input  wire logic [31:0]        error_value,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] value_out,
  input  wire logic [31:0]        gbest_error,
  input  wire logic [5:0]         best_particle,
  input  wire logic               improved,
  input  wire logic               flush,
  output int                      fail_count
);

  typedef struct packed {
    logic signed [31:0] value;
    logic [31:0]        berr;
    logic [5:0]         bpart;
    logic               impr;
  } swarm_result_t;

  swarm_result_t result_q[$];
  psue_pkg::cfg_t cfg;

  logic signed [31:0] pos_mem [psue_pkg::PARTICLES*psue_pkg::DIMS];
  logic signed [31:0] vel_mem [psue_pkg::PARTICLES*psue_pkg::DIMS];
  logic signed [31:0] pbest_mem [psue_pkg::PARTICLES*psue_pkg::DIMS];
  logic [31:0]        perr_mem [psue_pkg::PARTICLES];
  logic signed [31:0] gbest_mem [psue_pkg::DIMS];
  logic signed [31:0] lo_mem [psue_pkg::DIMS];
  logic signed [31:0] hi_mem [psue_pkg::DIMS];
  logic [31:0]        gerr;
  logic [5:0]         gidx;
  bit                 flushed;

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic signed [31:0] bounded(logic signed [31:0] v, int d);
    if (cfg.bound_position) return v;
    return 32'(clip(longint'(v), longint'(lo_mem[d]), longint'(hi_mem[d])));
  endfunction

  task automatic update_swarm(input logic [2:0] o, input int p, input int d,
                              input logic signed [31:0] a, input logic signed [31:0] b,
                              input logic [15:0] ro, input logic [15:0] rs,
                              input logic [31:0] err);
    swarm_result_t r;
    logic signed [31:0] cand [psue_pkg::DIMS];
    longint x, v, pb, nb, lo, hi, acc, nv, np, span;
    logic [31:0] c1, c2, e;
    int k, sel, left, right;
    r = '0;
    k = p * psue_pkg::DIMS + d;
    case (o)
      psue_pkg::OP_BOUNDS: begin
        lo_mem[d] = a;
        hi_mem[d] = b;
      end
      psue_pkg::OP_LOAD: begin
        pos_mem[k] = a;
        vel_mem[k] = b;
        perr_mem[p] = psue_pkg::ALL_ONES;
        gerr = psue_pkg::ALL_ONES;
        gidx = '0;
      end
      psue_pkg::OP_REPORT: begin
        for (int i = 0; i < psue_pkg::DIMS; i++)
          cand[i] = bounded(pos_mem[p*psue_pkg::DIMS+i], i);
        if (err < perr_mem[p]) begin
          for (int i = 0; i < psue_pkg::DIMS; i++) pbest_mem[p*psue_pkg::DIMS+i] = cand[i];
          perr_mem[p] = err;
          r.impr = 1'b1;
        end
        if (!cfg.topology && err < gerr) begin
          gerr = err;
          for (int i = 0; i < psue_pkg::DIMS; i++) gbest_mem[i] = cand[i];
          gidx = 6'(p);
        end
      end
      psue_pkg::OP_MOVE: begin
        x = pos_mem[k];
        v = vel_mem[k];
        pb = pbest_mem[k];
        lo = lo_mem[d];
        hi = hi_mem[d];
        if (cfg.topology) begin
          sel = p;
          e = perr_mem[p];
          left = (p == 0) ? psue_pkg::PARTICLES - 1 : p - 1;
          right = (p + 1) % psue_pkg::PARTICLES;
          if (perr_mem[left] < e) begin
            sel = left;
            e = perr_mem[left];
          end
          if (perr_mem[right] < e) sel = right;
          nb = pbest_mem[sel*psue_pkg::DIMS+d];
        end else begin
          nb = gbest_mem[d];
        end
        c1 = ({16'b0, ro} * {16'b0, cfg.own_pull}) >> 16;
        c2 = ({16'b0, rs} * {16'b0, cfg.swarm_pull}) >> 16;
        acc = longint'(cfg.inertia) * v + longint'(c1) * (pb - x) + longint'(c2) * (nb - x);
        nv = (acc + 8192) >>> 14;
        if (cfg.bound_velocity) begin
          span = hi - lo;
          if (span < 0) span = -span;
          nv = clip(nv, -span, span);
        end
        vel_mem[k] = 32'(clip(nv, -64'sd2147483648, 64'sd2147483647));
        np = x + longint'(vel_mem[k]);
        if (cfg.bound_position) np = clip(np, lo, hi);
        pos_mem[k] = 32'(clip(np, -64'sd2147483648, 64'sd2147483647));
        r.value = 32'(clip(longint'(pos_mem[k]), lo, hi));
      end
      psue_pkg::OP_ENDGEN: begin
        if (cfg.topology) begin
          gerr = psue_pkg::ALL_ONES;
          for (int i = 0; i < psue_pkg::PARTICLES; i++) begin
            if (perr_mem[i] < gerr) begin
              for (int j = 0; j < psue_pkg::DIMS; j++)
                gbest_mem[j] = bounded(pbest_mem[i*psue_pkg::DIMS+j], j);
              gerr = perr_mem[i];
              gidx = 6'(i);
            end
          end
        end
      end
      psue_pkg::OP_READ: r.value = gbest_mem[d];
      default: ;
    endcase
    r.berr = gerr;
    r.bpart = gidx;
    result_q.push_back(r);
  endtask

  always @(posedge clk) begin
    swarm_result_t exp_r;
    if (rst) begin
      cfg <= '{1'b0, 1'b0, 1'b0, psue_pkg::INERTIA_RST, psue_pkg::PULL_RST,
               psue_pkg::PULL_RST};
      for (int i = 0; i < psue_pkg::PARTICLES; i++) perr_mem[i] = psue_pkg::ALL_ONES;
      gerr = psue_pkg::ALL_ONES;
      gidx = '0;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          psue_pkg::REG_TOPOLOGY:   cfg.topology <= pwdata[0];
          psue_pkg::REG_BOUND_POS:  cfg.bound_position <= pwdata[0];
          psue_pkg::REG_BOUND_VEL:  cfg.bound_velocity <= pwdata[0];
          psue_pkg::REG_INERTIA:    cfg.inertia <= pwdata[15:0];
          psue_pkg::REG_OWN_PULL:   cfg.own_pull <= pwdata[15:0];
          psue_pkg::REG_SWARM_PULL: cfg.swarm_pull <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        update_swarm(op, int'(particle), int'(dimension), value_a, value_b, rand_own,
                     rand_swarm, error_value);
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result transaction with no expected result");
          fail_count = fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (value_out !== exp_r.value) begin
            $error("value_out expected %0d actual %0d", exp_r.value, value_out);
            fail_count = fail_count + 1;
          end
          if (gbest_error !== exp_r.berr) begin
            $error("gbest_error expected %0h actual %0h", exp_r.berr, gbest_error);
            fail_count = fail_count + 1;
          end
          if (best_particle !== exp_r.bpart) begin
            $error("best_particle expected %0d actual %0d", exp_r.bpart, best_particle);
            fail_count = fail_count + 1;
          end
          if (improved !== exp_r.impr) begin
            $error("improved expected %0d actual %0d", exp_r.impr, improved);
            fail_count = fail_count + 1;
          end
        end
      end
      if (flush && !flushed) begin
        flushed = 1'b1;
        if (result_q.size() != 0) begin
          $error("%0d expected results never arrived", result_q.size());
          fail_count = fail_count + 1;
        end
      end
    end
  end

endmodule

>>> dv/particle_swarm_update_engine_tb.sv
// Stimulus and verdict for the particle swarm update engine testbench.
`timescale 1ns / 100ps
module particle_swarm_update_engine_tb;

  typedef struct {
    logic [2:0]         op;
    logic [5:0]         p;
    logic [3:0]         d;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [15:0]        ro;
    logic [15:0]        rs;
    logic [31:0]        err;
  } swarm_item_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic [2:0] op = '0;
  logic [5:0] particle = '0;
  logic [3:0] dimension = '0;
  logic signed [31:0] value_a = '0, value_b = '0;
  logic [15:0] rand_own = '0, rand_swarm = '0;
  logic [31:0] error_value = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] value_out;
  logic [31:0] gbest_error;
  logic [5:0] best_particle;
  logic improved;
  logic flush = 1'b0;
  int fail_count;

  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int sent_cnt = 0, recv_cnt = 0, quiet_cycles = 0;

  bit pos_def [psue_pkg::PARTICLES][psue_pkg::DIMS];
  bit pb_def [psue_pkg::PARTICLES];
  bit gb_def = 1'b0;
  bit topo_now = 1'b0;

  particle_swarm_update_engine dut (.*);

  psue_scoreboard u_scoreboard (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_ready) sent_cnt <= sent_cnt + 1;
    if (out_valid && out_ready) recv_cnt <= recv_cnt + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("particle_swarm_update_engine_tb failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input bit topo, input bit bpos, input bit bvel,
                           input logic [15:0] w, input logic [15:0] p1,
                           input logic [15:0] p2);
    reg_write(psue_pkg::REG_TOPOLOGY, {31'b0, topo});
    reg_write(psue_pkg::REG_BOUND_POS, {31'b0, bpos});
    reg_write(psue_pkg::REG_BOUND_VEL, {31'b0, bvel});
    reg_write(psue_pkg::REG_INERTIA, {16'b0, w});
    reg_write(psue_pkg::REG_OWN_PULL, {16'b0, p1});
    reg_write(psue_pkg::REG_SWARM_PULL, {16'b0, p2});
    topo_now = topo;
  endtask

  task automatic send(input swarm_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= it.op;
    particle <= it.p;
    dimension <= it.d;
    value_a <= it.a;
    value_b <= it.b;
    rand_own <= it.ro;
    rand_swarm <= it.rs;
    error_value <= it.err;
    if (it.op == psue_pkg::OP_LOAD) pos_def[it.p][it.d] = 1'b1;
    if (it.op == psue_pkg::OP_REPORT) begin
      pb_def[it.p] = 1'b1;
      if (!topo_now) gb_def = 1'b1;
    end
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (recv_cnt != sent_cnt) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(8 << 16)) - (4 << 16);
      2: case ($urandom_range(2))
           0: return 32'sh8000_0000;
           1: return 32'sh7FFF_FFFF;
           default: return 0;
         endcase
      default: return $signed($urandom_range(2000 << 16)) - (1000 << 16);
    endcase
  endfunction

  function automatic swarm_item_t mk(logic [2:0] o, logic [5:0] p, logic [3:0] d,
                                     logic signed [31:0] a, logic signed [31:0] b,
                                     logic [31:0] err);
    swarm_item_t it;
    it.op = o;
    it.p = p;
    it.d = d;
    it.a = a;
    it.b = b;
    it.ro = 16'($urandom);
    it.rs = 16'($urandom);
    it.err = err;
    return it;
  endfunction

  function automatic logic [31:0] rand_err();
    logic [31:0] e;
    e = $urandom_range(1) ? $urandom_range(5000) : $urandom;
    if (e == psue_pkg::ALL_ONES) e = psue_pkg::ALL_ONES - 1;
    return e;
  endfunction

  function automatic swarm_item_t gen_item();
    swarm_item_t it;
    int r, gap;
    bit full;
    it = mk(psue_pkg::OP_LOAD,
            ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7)),
            4'($urandom_range(15)), rand_q(), rand_q(), rand_err());
    r = $urandom_range(99);
    if (r < 4) it.op = psue_pkg::OP_BOUNDS;
    else if (r < 26) it.op = psue_pkg::OP_LOAD;
    else if (r < 46) it.op = psue_pkg::OP_REPORT;
    else if (r < 84) it.op = psue_pkg::OP_MOVE;
    else if (r < 89) it.op = psue_pkg::OP_ENDGEN;
    else if (r < 97) it.op = psue_pkg::OP_READ;
    else it.op = 3'($urandom_range(6, 7));
    if ($urandom_range(9) == 0) begin
      it.ro = 16'hFFFF;
      it.rs = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    gap = -1;
    for (int i = psue_pkg::DIMS - 1; i >= 0; i--) if (!pos_def[it.p][i]) gap = i;
    full = (gap < 0);
    if (it.op == psue_pkg::OP_MOVE && !pos_def[it.p][it.d]) it.op = psue_pkg::OP_LOAD;
    else if (it.op == psue_pkg::OP_MOVE && (!pb_def[it.p] || (!topo_now && !gb_def)))
      it.op = psue_pkg::OP_REPORT;
    if (it.op == psue_pkg::OP_READ && !gb_def)
      it.op = topo_now ? psue_pkg::OP_LOAD : psue_pkg::OP_REPORT;
    if (it.op == psue_pkg::OP_REPORT && !full) begin
      it.op = psue_pkg::OP_LOAD;
      it.d = 4'(gap);
    end
    return it;
  endfunction

  task automatic random_phase(input int n);
    repeat (n) send(gen_item());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send(mk(psue_pkg::OP_BOUNDS, 6'd0, 4'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'd0));
    send(mk(psue_pkg::OP_BOUNDS, 6'd0, 4'd1, 5 << 16, -(5 << 16), 32'd0));
    send(mk(psue_pkg::OP_BOUNDS, 6'd0, 4'd15, 0, 0, 32'd0));
    for (int i = 2; i < 15; i++)
      send(mk(psue_pkg::OP_BOUNDS, 6'd0, 4'(i), -(10 << 16), 10 << 16, 32'd0));
    send(mk(3'd6, 6'd63, 4'd15, 32'sh7FFF_FFFF, 32'sh8000_0000, psue_pkg::ALL_ONES - 1));
    send(mk(3'd7, 6'd0, 4'd0, 0, 0, 32'd0));
    send(mk(psue_pkg::OP_ENDGEN, 6'd0, 4'd0, 0, 0, 32'd0));
    send(mk(psue_pkg::OP_LOAD, 6'd63, 4'd15, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'd0));
    send(mk(psue_pkg::OP_LOAD, 6'd0, 4'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'd0));
    random_phase(190);
    wait_drained();

    configure(1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_idle_pct = 64;
    random_phase(210);
    wait_drained();

    configure(1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_idle_pct = 0;
    recv_stall_pct = 64;
    random_phase(40);
    hold_req = 1'b1;
    random_phase(170);
    wait_drained();

    configure(1'b1, 1'b0, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    send_idle_pct = 14;
    recv_stall_pct = 14;
    random_phase(210);
    wait_drained();

    flush <= 1'b1;
    repeat (3) @(negedge clk);
    if (fail_count == 0) $display("particle_swarm_update_engine_tb passed");
    else $display("particle_swarm_update_engine_tb failed");
    $finish;
  end

endmodule
